### design/sll_pkg.sv
// Shared types and codes for the static linked list engine.
// No dependencies; imported by the top level.
package sll_pkg;

    localparam int VAL_W = 32;

    typedef logic [1:0]       kind_t;
    typedef logic [1:0]       status_t;
    typedef logic [VAL_W-1:0] value_t;

    localparam kind_t KIND_PUSH   = 2'd0;
    localparam kind_t KIND_INSERT = 2'd1;
    localparam kind_t KIND_DELETE = 2'd2;
    localparam kind_t KIND_DUMP   = 2'd3;

    localparam status_t ST_OK     = 2'd0;
    localparam status_t ST_FULL   = 2'd1;
    localparam status_t ST_BADPOS = 2'd2;
    localparam status_t ST_NONE   = 2'd3;

endpackage

### design/sll_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/static_linked_list_engine.sv
// Top level of the static linked list engine: sequencer, head and fill registers.
// Depends on sll_pkg and on sll_ram for the value and link memories.

// Singly linked list of up to NODES nodes held in a value memory and a link memory,
// nodes handed out in insertion order. One input beat is one operation and the block
// takes no new beat until that operation has put its last result into the output
// register. Every link read goes through the single read port of the link memory,
// whose read data is registered, and a dump yields one beat per list element. Bad
// requests are answered with a status beat and change nothing. No clearing pass is
// needed after reset.
module static_linked_list_engine
    import sll_pkg::*;
#(
    parameter int NODES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  kind_t                            kind,
    input  logic [$clog2(NODES+1)-1:0]       position,
    input  logic signed [VAL_W-1:0]          item_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [VAL_W-1:0]          out_value,
    output status_t                          status,
    output logic                             last
);

    localparam int CW = $clog2(NODES + 1);   // node count, position, link incl. null
    localparam int IW = $clog2(NODES);       // memory index
    localparam logic [CW-1:0] NULL_LINK = CW'(NODES);
    localparam logic [CW-1:0] LAST_CNT  = CW'(NODES - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_LINK1  = 3'd2;
    localparam logic [2:0] S_LINK2  = 3'd3;
    localparam logic [2:0] S_INS2   = 3'd4;
    localparam logic [2:0] S_DUMP   = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [2:0]    state_reg, state_next;
    kind_t         kind_reg, kind_next;
    logic [CW-1:0] pos_reg, pos_next;
    value_t        val_reg, val_next;
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    status_t       st_reg, st_next;

    logic          out_valid_reg, out_valid_next;
    value_t        out_value_reg, out_value_next;
    status_t       status_reg, status_next;
    logic          last_reg, last_next;

    logic          v_we, v_re;
    logic [IW-1:0] v_waddr, v_raddr;
    value_t        v_wdata, v_rdata;
    logic          l_we, l_re;
    logic [IW-1:0] l_waddr, l_raddr;
    logic [CW-1:0] l_wdata, l_rdata;

    logic          out_free;
    logic          full;
    logic          pos_bad;
    logic [IW-1:0] k_idx;
    logic          dump_fin;

    assign out_free = !out_valid_reg || out_ready;
    assign full     = (used_reg >= NULL_LINK);
    assign pos_bad  = (pos_reg > used_reg);
    assign k_idx    = IW'(pos_reg - CW'(1));
    assign dump_fin = (l_rdata >= NULL_LINK) || (cnt_reg == LAST_CNT);

    sll_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_values (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .re    (v_re),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    sll_ram #(.WIDTH(CW), .DEPTH(NODES)) u_links (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_waddr),
        .wdata (l_wdata),
        .re    (l_re),
        .raddr (l_raddr),
        .rdata (l_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        head_next      = head_reg;
        used_next      = used_reg;
        cnt_next       = cnt_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        v_we    = 1'b0;
        v_waddr = used_reg[IW-1:0];
        v_wdata = val_reg;
        v_re    = 1'b0;
        v_raddr = head_reg[IW-1:0];
        l_we    = 1'b0;
        l_waddr = used_reg[IW-1:0];
        l_wdata = head_reg;
        l_re    = 1'b0;
        l_raddr = k_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = kind;
                    pos_next   = position;
                    val_next   = item_value;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESULT;
                st_next    = ST_OK;
                case (kind_reg)
                    KIND_PUSH:
                    begin
                        if (full)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            v_we      = 1'b1;
                            l_we      = 1'b1;
                            head_next = used_reg;
                            used_next = used_reg + CW'(1);
                        end
                    end
                    KIND_INSERT:
                    begin
                        if (pos_reg == '0 || pos_bad)
                        begin
                            st_next = ST_BADPOS;
                        end
                        else if (full)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            l_re       = 1'b1;
                            state_next = S_LINK1;
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (pos_reg == '0)
                        begin
                            if (head_reg >= NULL_LINK)
                            begin
                                st_next = ST_NONE;
                            end
                            else
                            begin
                                l_re       = 1'b1;
                                l_raddr    = head_reg[IW-1:0];
                                state_next = S_LINK1;
                            end
                        end
                        else if (pos_bad)
                        begin
                            st_next = ST_BADPOS;
                        end
                        else
                        begin
                            l_re       = 1'b1;
                            state_next = S_LINK1;
                        end
                    end
                    default:
                    begin
                        // dump: empty list answers with a single status beat
                        if (head_reg >= NULL_LINK)
                        begin
                            st_next = ST_NONE;
                        end
                        else
                        begin
                            v_re       = 1'b1;
                            l_re       = 1'b1;
                            l_raddr    = head_reg[IW-1:0];
                            cnt_next   = '0;
                            state_next = S_DUMP;
                        end
                    end
                endcase
            end
            S_LINK1:
            begin
                if (kind_reg == KIND_INSERT)
                begin
                    // new node takes over the old successor of node k
                    v_we       = 1'b1;
                    l_we       = 1'b1;
                    l_wdata    = l_rdata;
                    state_next = S_INS2;
                end
                else if (pos_reg == '0)
                begin
                    head_next  = l_rdata;
                    state_next = S_RESULT;
                end
                else if (l_rdata >= NULL_LINK)
                begin
                    st_next    = ST_NONE;
                    state_next = S_RESULT;
                end
                else
                begin
                    l_re       = 1'b1;
                    l_raddr    = l_rdata[IW-1:0];
                    state_next = S_LINK2;
                end
            end
            S_LINK2:
            begin
                l_we       = 1'b1;
                l_waddr    = k_idx;
                l_wdata    = l_rdata;
                state_next = S_RESULT;
            end
            S_INS2:
            begin
                l_we       = 1'b1;
                l_waddr    = k_idx;
                l_wdata    = used_reg;
                used_next  = used_reg + CW'(1);
                state_next = S_RESULT;
            end
            S_DUMP:
            begin
                // memory data hold while the output side stalls
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = v_rdata;
                    status_next    = ST_OK;
                    last_next      = dump_fin;
                    cnt_next       = cnt_reg + CW'(1);
                    if (dump_fin)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        v_re    = 1'b1;
                        v_raddr = l_rdata[IW-1:0];
                        l_re    = 1'b1;
                        l_raddr = l_rdata[IW-1:0];
                    end
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    status_next    = st_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= NULL_LINK;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        cnt_reg       <= cnt_next;
        st_reg        <= st_next;
        out_value_reg <= out_value_next;
        status_reg    <= status_next;
        last_reg      <= last_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign status    = status_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= NULL_LINK)
        else $error("node count above capacity");

    a_head_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg == NULL_LINK || head_reg < used_reg)
        else $error("head points at an unallocated node");

    a_dump_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |-> cnt_reg < used_reg)
        else $error("dump walked more nodes than allocated");

    a_mid_beat_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> status == ST_OK)
        else $error("non-final beat carries an error status");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != $past(used_reg) |-> $past(state_reg) == S_EXEC
            || $past(state_reg) == S_INS2)
        else $error("node count changed outside an allocation step");
`endif

endmodule

### sim/static_linked_list_engine_tb.sv
`timescale 1ns / 1ps
// Testbench for static_linked_list_engine: directed table, then random list edits and dumps.
// Depends on sll_pkg and the engine RTL; checks result beats against a predictor or typed rows.
module static_linked_list_engine_tb;
    import sll_pkg::*;

    localparam int NODES          = 64;
    localparam int DIRECTED_ROWS  = 22;
    localparam int RANDOM_OPS     = 290;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;

    typedef struct packed {
        value_t  value;
        status_t st;
        logic    last;
    } beat_t;

    typedef struct {
        kind_t   k;
        int      pos;
        value_t  v;
        bit      typed;
        status_t st;
    } op_row_t;

    logic                    clk        = 1'b0;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_ready;
    kind_t                   kind       = KIND_PUSH;
    logic [6:0]              position   = '0;
    logic signed [VAL_W-1:0] item_value = '0;
    logic                    out_valid;
    logic                    out_ready  = 1'b0;
    logic signed [VAL_W-1:0] out_value;
    status_t                 status;
    logic                    last;

    static_linked_list_engine #(.NODES(NODES)) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .position   (position),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_value  (out_value),
        .status     (status),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // list predictor: node store, head and fill count; NODES marks a null link
    value_t node_val [NODES];
    int     node_nxt [NODES];
    int     head_node = NODES;
    int     fill      = 0;
    beat_t  expected_beats [$];

    int errors      = 0;
    int beats_seen  = 0;
    int ops_sent    = 0;
    int dumps_sent  = 0;
    int drain_waits = 0;
    bit feed_calm   = 1'b0;
    bit sink_calm   = 1'b0;
    int sink_hold   = 0;
    int idle_cycles = 0;
    beat_t want;

    // rows with a typed result are the ones readable at a glance; the rest use the predictor
    op_row_t directed_ops [DIRECTED_ROWS] = '{
        '{KIND_DUMP,   0,   32'h0000_0000, 1'b1, ST_NONE},
        '{KIND_DELETE, 0,   32'h0000_0000, 1'b1, ST_NONE},
        '{KIND_INSERT, 0,   32'h1234_5678, 1'b1, ST_BADPOS},
        '{KIND_INSERT, 1,   32'h1234_5678, 1'b1, ST_BADPOS},
        '{KIND_DELETE, 1,   32'h0000_0000, 1'b1, ST_BADPOS},
        '{KIND_PUSH,   0,   32'h7FFF_FFFF, 1'b1, ST_OK},
        '{KIND_PUSH,   127, 32'h8000_0000, 1'b1, ST_OK},
        '{KIND_PUSH,   0,   32'hFFFF_FFFF, 1'b1, ST_OK},
        '{KIND_INSERT, 1,   32'h5555_5555, 1'b0, ST_OK},
        '{KIND_INSERT, 4,   32'hAAAA_AAAA, 1'b0, ST_OK},
        '{KIND_INSERT, 6,   32'h0000_0001, 1'b1, ST_BADPOS},
        '{KIND_DUMP,   0,   32'h0000_0000, 1'b0, ST_OK},
        '{KIND_DELETE, 1,   32'h0000_0000, 1'b0, ST_OK},
        '{KIND_DELETE, 0,   32'h0000_0000, 1'b0, ST_OK},
        '{KIND_DELETE, 5,   32'h0000_0000, 1'b1, ST_NONE},
        // node 3 was unlinked from the head: edits to it stay invisible
        '{KIND_INSERT, 3,   32'h0000_0001, 1'b0, ST_OK},
        '{KIND_DELETE, 3,   32'h0000_0000, 1'b0, ST_OK},
        '{KIND_DUMP,   127, 32'hFFFF_FFFF, 1'b0, ST_OK},
        '{KIND_INSERT, 127, 32'hFFFF_FFFF, 1'b1, ST_BADPOS},
        '{KIND_DELETE, 64,  32'h0000_0000, 1'b1, ST_BADPOS},
        '{KIND_DELETE, 0,   32'h0000_0000, 1'b0, ST_OK},
        '{KIND_DUMP,   0,   32'h0000_0000, 1'b0, ST_OK}
    };

    task automatic log_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        errors++;
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // applies one operation to the predicted list and queues the beats it yields
    function automatic void apply_list_op(input kind_t k, input int pos, input value_t v);
        beat_t b;
        int    cur;
        int    nxt;
        int    n;
        b = '{value: '0, st: ST_OK, last: 1'b1};
        if (k == KIND_DUMP)
        begin
            cur = head_node;
            if (cur >= NODES)
            begin
                b.st = ST_NONE;
                expected_beats.push_back(b);
                return;
            end
            n = 0;
            while (cur < NODES && n < NODES)
            begin
                nxt     = node_nxt[cur];
                b.value = node_val[cur];
                b.last  = (nxt >= NODES) || (n + 1 >= NODES);
                expected_beats.push_back(b);
                n++;
                cur = nxt;
            end
            return;
        end
        case (k)
            KIND_PUSH:
                if (fill >= NODES)
                    b.st = ST_FULL;
                else
                begin
                    node_val[fill] = v;
                    node_nxt[fill] = head_node;
                    head_node      = fill;
                    fill++;
                end
            KIND_INSERT:
                if (pos == 0 || pos > fill)
                    b.st = ST_BADPOS;
                else if (fill >= NODES)
                    b.st = ST_FULL;
                else
                begin
                    node_val[fill]    = v;
                    node_nxt[fill]    = node_nxt[pos-1];
                    node_nxt[pos-1]   = fill;
                    fill++;
                end
            default:
                if (pos == 0)
                begin
                    if (head_node >= NODES)
                        b.st = ST_NONE;
                    else
                        head_node = node_nxt[head_node];
                end
                else if (pos > fill)
                    b.st = ST_BADPOS;
                else
                begin
                    cur = node_nxt[pos-1];
                    if (cur >= NODES)
                        b.st = ST_NONE;
                    else
                        node_nxt[pos-1] = node_nxt[cur];
                end
        endcase
        expected_beats.push_back(b);
    endfunction

    // drives one beat, predicts on acceptance, then idles a random gap
    task automatic send_beat(input kind_t k, input int pos, input value_t v,
                             input bit typed, input status_t st);
        int depth;
        int gap;
        kind       <= k;
        position   <= pos[6:0];
        item_value <= v;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        depth = expected_beats.size();
        apply_list_op(k, pos, v);
        if (typed)
        begin
            while (expected_beats.size() > depth)
                void'(expected_beats.pop_back());
            expected_beats.push_back('{value: '0, st: st, last: 1'b1});
        end
        ops_sent++;
        if (k == KIND_DUMP)
            dumps_sent++;
        if ($urandom_range(0, 39) == 0)
            feed_calm = !feed_calm;
        gap = pick_gap(feed_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: random back-pressure and the in-order check
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            beats_seen++;
            if (expected_beats.size() == 0)
                log_mismatch($sformatf("unexpected beat value %h status %0d last %0b",
                                       out_value, status, last));
            else
            begin
                want = expected_beats.pop_front();
                if (out_value !== want.value)
                    log_mismatch($sformatf("out_value %h, expected %h", out_value, want.value));
                if (status !== want.st)
                    log_mismatch($sformatf("status %0d, expected %0d", status, want.st));
                if (last !== want.last)
                    log_mismatch($sformatf("last %0b, expected %0b", last, want.last));
            end
        end
        if ($urandom_range(0, 149) == 0)
            sink_calm = !sink_calm;
        if (sink_hold > 0)
        begin
            out_ready <= 1'b0;
            sink_hold--;
        end
        else
        begin
            sink_hold = pick_gap(sink_calm);
            out_ready <= (sink_hold == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int     r;
        int     pos;
        kind_t  k;
        value_t v;
        bit     drained_at_full;
        drained_at_full = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_beat(directed_ops[i].k, directed_ops[i].pos, directed_ops[i].v,
                      directed_ops[i].typed, directed_ops[i].st);

        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            r = $urandom_range(0, 99);
            // while growing, mostly edits that land; once full, mostly deletes and dumps
            if (fill < NODES)
            begin
                if (r < 30)      k = KIND_PUSH;
                else if (r < 65) k = KIND_INSERT;
                else if (r < 85) k = KIND_DELETE;
                else             k = KIND_DUMP;
            end
            else
            begin
                if (r < 10)      k = KIND_PUSH;
                else if (r < 30) k = KIND_INSERT;
                else if (r < 70) k = KIND_DELETE;
                else             k = KIND_DUMP;
            end
            if ($urandom_range(0, 9) < 2)
                pos = $urandom_range(0, 127);
            else if (k == KIND_INSERT)
                pos = (fill > 0) ? $urandom_range(1, fill) : 0;
            else if (k == KIND_DELETE)
                pos = $urandom_range(0, fill);
            else
                pos = $urandom_range(0, 127);
            case ($urandom_range(0, 15))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'hFFFF_FFFF;
                3:       v = 32'h0000_0000;
                default: v = $urandom();
            endcase
            send_beat(k, pos, v, 1'b0, ST_OK);

            // hold off the sender until the result side has drained
            if ((fill == NODES && !drained_at_full) || $urandom_range(0, 49) == 0)
            begin
                drained_at_full = drained_at_full || (fill == NODES);
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_beats.size() != 0);
                drain_waits++;
            end
        end

        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run: %0d operations (%0d dumps), %0d result beats checked",
                 ops_sent, dumps_sent, beats_seen);
        $display("Store filled to %0d of %0d nodes, %0d drain pauses, %0d mismatches",
                 fill, NODES, drain_waits, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
